@@ design/lr_pkg.sv @@
// shared types and constants of the line rasterizer
package lr_pkg;

	// item kinds carried in the input tuser
	typedef enum logic {
		CMD_START   = 1'b0,
		CMD_ADVANCE = 1'b1
	} cmd_t;

	// colour register
	localparam int COLOR_BITS = 16;
	localparam logic [COLOR_BITS-1:0] COLOR_RESET = 16'hFFFF;

	// configuration port
	localparam int APB_ADDR_BITS = 3;
	localparam int APB_DATA_BITS = 32;
	localparam logic REG_DRAW_COLOR = 1'b0;

	// status of one processed item, from the core to the output stage
	typedef struct packed {
		logic emit;
		logic last;
		logic active;
	} core_status_t;

endpackage

@@ design/lr_apb.sv @@
// configuration registers behind the apb-style port
module lr_apb
	import lr_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [APB_ADDR_BITS-1:0] paddr,
	input  logic [APB_DATA_BITS-1:0] pwdata,
	output logic [APB_DATA_BITS-1:0] prdata,
	output logic                     pready,
	output logic [COLOR_BITS-1:0]    draw_color
);

	logic [COLOR_BITS-1:0] draw_color_q;
	logic                  reg_index;
	logic                  wr_en;

	// word index of the register
	assign reg_index = paddr[2];
	assign pready    = 1'b1;
	assign wr_en     = psel & penable & pwrite & pready & (reg_index == REG_DRAW_COLOR);

	// colour register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			draw_color_q <= COLOR_RESET;
		end else if (wr_en) begin
			draw_color_q <= pwdata[COLOR_BITS-1:0];
		end
	end

	// read back
	always_comb begin
		prdata = '0;
		if (reg_index == REG_DRAW_COLOR) begin
			prdata = {{(APB_DATA_BITS-COLOR_BITS){1'b0}}, draw_color_q};
		end
	end

	assign draw_color = draw_color_q;

endmodule

@@ design/lr_core.sv @@
// line state registers and the single-pass bresenham step
module lr_core
	import lr_pkg::*;
#(
	parameter int COORD_BITS = 10
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  fire,
	input  cmd_t                  cmd,
	input  logic [COORD_BITS-1:0] sx,
	input  logic [COORD_BITS-1:0] sy,
	input  logic [COORD_BITS-1:0] ex,
	input  logic [COORD_BITS-1:0] ey,
	output logic [COORD_BITS-1:0] pix_x,
	output logic [COORD_BITS-1:0] pix_y,
	output core_status_t          status
);

	localparam int ERR_BITS = COORD_BITS + 3;
	localparam logic [COORD_BITS-1:0] COORD_ONE = COORD_BITS'(1);

	// line state
	logic                       active_q, active_d;
	logic [COORD_BITS-1:0]      cur_x_q, cur_x_d;
	logic [COORD_BITS-1:0]      cur_y_q, cur_y_d;
	logic [COORD_BITS-1:0]      end_major_q, end_major_d;
	logic [COORD_BITS-1:0]      major_delta_q, major_delta_d;
	logic [COORD_BITS:0]        minor_twice_q, minor_twice_d;
	logic [COORD_BITS:0]        major_twice_q, major_twice_d;
	logic signed [ERR_BITS-1:0] err_q, err_d;
	logic                       x_neg_q, x_neg_d;
	logic                       y_neg_q, y_neg_d;
	logic                       x_major_q, x_major_d;

	// start-item deltas
	logic [COORD_BITS-1:0]      adx, ady;
	logic                       sx_neg, sy_neg, sx_major;
	logic [COORD_BITS-1:0]      major_sel, minor_sel;

	// advance datapath
	logic [COORD_BITS-1:0]      x_step, y_step;
	logic signed [ERR_BITS-1:0] err_add, err_sub;
	logic                       minor_step;
	logic [COORD_BITS-1:0]      adv_x, adv_y, major_now;
	logic                       emit;
	logic                       last;

	// deltas and axis choice of a new line
	always_comb begin
		sx_neg    = ex < sx;
		sy_neg    = ey < sy;
		adx       = sx_neg ? (sx - ex) : (ex - sx);
		ady       = sy_neg ? (sy - ey) : (ey - sy);
		sx_major  = ady <= adx;
		major_sel = sx_major ? adx : ady;
		minor_sel = sx_major ? ady : adx;
	end

	// one bresenham step from the registered state
	always_comb begin
		x_step     = x_neg_q ? (cur_x_q - COORD_ONE) : (cur_x_q + COORD_ONE);
		y_step     = y_neg_q ? (cur_y_q - COORD_ONE) : (cur_y_q + COORD_ONE);
		err_add    = err_q + $signed({2'b00, minor_twice_q});
		minor_step = err_add > $signed({3'b000, major_delta_q});
		err_sub    = err_add - $signed({2'b00, major_twice_q});
		adv_x      = (x_major_q || minor_step) ? x_step : cur_x_q;
		adv_y      = (!x_major_q || minor_step) ? y_step : cur_y_q;
		major_now  = x_major_q ? adv_x : adv_y;
	end

	// next state and emitted pixel
	always_comb begin
		active_d      = active_q;
		cur_x_d       = cur_x_q;
		cur_y_d       = cur_y_q;
		end_major_d   = end_major_q;
		major_delta_d = major_delta_q;
		minor_twice_d = minor_twice_q;
		major_twice_d = major_twice_q;
		err_d         = err_q;
		x_neg_d       = x_neg_q;
		y_neg_d       = y_neg_q;
		x_major_d     = x_major_q;
		pix_x         = cur_x_q;
		pix_y         = cur_y_q;
		emit          = 1'b0;
		last          = 1'b0;
		if (fire) begin
			if (cmd == CMD_START) begin
				x_neg_d       = sx_neg;
				y_neg_d       = sy_neg;
				x_major_d     = sx_major;
				major_delta_d = major_sel;
				minor_twice_d = {minor_sel, 1'b0};
				major_twice_d = {major_sel, 1'b0};
				end_major_d   = sx_major ? ex : ey;
				err_d         = '0;
				cur_x_d       = sx;
				cur_y_d       = sy;
				active_d      = (adx != '0) || (ady != '0);
				pix_x         = sx;
				pix_y         = sy;
				emit          = 1'b1;
				last          = !active_d;
			end else if (active_q) begin
				cur_x_d     = adv_x;
				cur_y_d     = adv_y;
				err_d       = minor_step ? err_sub : err_add;
				last        = major_now == end_major_q;
				active_d    = !last;
				pix_x       = adv_x;
				pix_y       = adv_y;
				emit        = 1'b1;
			end
		end
	end

	assign status.emit   = emit;
	assign status.last   = last;
	assign status.active = active_q;

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q      <= 1'b0;
			cur_x_q       <= '0;
			cur_y_q       <= '0;
			end_major_q   <= '0;
			major_delta_q <= '0;
			minor_twice_q <= '0;
			major_twice_q <= '0;
			err_q         <= '0;
			x_neg_q       <= 1'b0;
			y_neg_q       <= 1'b0;
			x_major_q     <= 1'b0;
		end else begin
			active_q      <= active_d;
			cur_x_q       <= cur_x_d;
			cur_y_q       <= cur_y_d;
			end_major_q   <= end_major_d;
			major_delta_q <= major_delta_d;
			minor_twice_q <= minor_twice_d;
			major_twice_q <= major_twice_d;
			err_q         <= err_d;
			x_neg_q       <= x_neg_d;
			y_neg_q       <= y_neg_d;
			x_major_q     <= x_major_d;
		end
	end

endmodule

@@ design/line_rasterizer.sv @@
// top level of the bresenham line rasterizer
//
//  channel   | direction | payload
//  ----------+-----------+-------------------------------------------------
//  s_*       | in        | tdata: start_x, start_y, end_x, end_y; tuser: command
//  m_*       | out       | tdata: pixel_x, pixel_y, pixel_color; tlast: last_pixel
//  apb       | in        | draw_color at byte address 0
//
//  an item is registered on entry, processed against the line state by the
//  core logic and lands in the output register, which drives tvalid
//  one item per cycle is sustained while the output does not stall; the limit
//  is the single add, compare and subtract on the error term between the input
//  and output registers
//  a stalled output holds the input register, which then drops s_tready
//  reset clears the line state, the valid flags and sets the colour to white
module line_rasterizer
	import lr_pkg::*;
#(
	parameter int COORD_BITS = 10
) (
	input  logic                     clk,
	input  logic                     arst_n,
	// configuration port
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [APB_ADDR_BITS-1:0] paddr,
	input  logic [APB_DATA_BITS-1:0] pwdata,
	output logic [APB_DATA_BITS-1:0] prdata,
	output logic                     pready,
	// command stream
	input  logic                     s_tvalid,
	output logic                     s_tready,
	// start_x, start_y, end_x, end_y
	input  logic [((4*COORD_BITS+7)/8)*8-1:0] s_tdata,
	// command
	input  logic                     s_tuser,
	// pixel stream
	output logic                     m_tvalid,
	input  logic                     m_tready,
	// pixel_x, pixel_y, pixel_color
	output logic [((2*COORD_BITS+COLOR_BITS+7)/8)*8-1:0] m_tdata,
	output logic                     m_tlast
);

	localparam int OUT_BITS = ((2*COORD_BITS+COLOR_BITS+7)/8)*8;
	localparam int OUT_USED = 2*COORD_BITS + COLOR_BITS;

	logic [COLOR_BITS-1:0] draw_color;

	// input stage
	logic                  valid_s1;
	cmd_t                  cmd_s1;
	logic [COORD_BITS-1:0] sx_s1, sy_s1, ex_s1, ey_s1;
	logic                  fire;

	// core results
	logic [COORD_BITS-1:0] pix_x, pix_y;
	core_status_t          status;

	// output stage
	logic                  valid_s2;
	logic [COORD_BITS-1:0] pix_x_s2, pix_y_s2;
	logic [COLOR_BITS-1:0] color_s2;
	logic                  last_s2;

	lr_apb u_apb (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.draw_color (draw_color)
	);

	// the held item moves on when the output slot is free or being emptied
	assign fire     = valid_s1 & (~valid_s2 | m_tready);
	assign s_tready = ~valid_s1 | fire;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_s1 <= cmd_t'(s_tuser);
			sx_s1  <= s_tdata[0*COORD_BITS +: COORD_BITS];
			sy_s1  <= s_tdata[1*COORD_BITS +: COORD_BITS];
			ex_s1  <= s_tdata[2*COORD_BITS +: COORD_BITS];
			ey_s1  <= s_tdata[3*COORD_BITS +: COORD_BITS];
		end
	end

	lr_core #(
		.COORD_BITS (COORD_BITS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.cmd    (cmd_s1),
		.sx     (sx_s1),
		.sy     (sy_s1),
		.ex     (ex_s1),
		.ey     (ey_s1),
		.pix_x  (pix_x),
		.pix_y  (pix_y),
		.status (status)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (fire) begin
			valid_s2 <= status.emit;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && status.emit) begin
			pix_x_s2 <= pix_x;
			pix_y_s2 <= pix_y;
			color_s2 <= draw_color;
			last_s2  <= status.last;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tlast  = last_s2;
	assign m_tdata  = {{(OUT_BITS-OUT_USED){1'b0}}, color_s2, pix_y_s2, pix_x_s2};

	// a start always yields a pixel
	a_start_emits: assert property (@(posedge clk) disable iff (!arst_n)
		fire && (cmd_s1 == CMD_START) |=> m_tvalid)
		else $error("start transaction produced no pixel");

	// the last pixel closes the line
	a_last_idles: assert property (@(posedge clk) disable iff (!arst_n)
		fire && status.emit && status.last |=> !status.active)
		else $error("line still active after last pixel");

	// an item that yields nothing leaves the output empty
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		fire && !status.emit |=> !m_tvalid)
		else $error("pixel appeared without a producing item");

endmodule

@@ test/testbench.sv @@
// testbench of the line rasterizer: directed and random lines checked against a cycle-free predictor
`timescale 1ns / 1ps

module testbench
	import lr_pkg::*;
();

	localparam int COORD_BITS  = 10;
	localparam int COORD_MAX   = (1 << COORD_BITS) - 1;
	localparam int S_DATA_BITS = ((4*COORD_BITS+7)/8)*8;
	localparam int M_DATA_BITS = ((2*COORD_BITS+COLOR_BITS+7)/8)*8;
	localparam int STALL_LIMIT = 3000;
	localparam int DRAIN_CYCLES = 8;
	localparam int GAP_CAP     = 40;
	localparam int HOLD_CYCLES = 200;

	typedef logic [COORD_BITS-1:0] coord_t;
	typedef logic [COLOR_BITS-1:0] colour_t;

	typedef struct {
		coord_t  x;
		coord_t  y;
		colour_t colour;
		logic    last;
	} pixel_t;

	logic                     clk;
	logic                     arst_n    = 1'b0;
	logic                     psel      = 1'b0;
	logic                     penable   = 1'b0;
	logic                     pwrite    = 1'b0;
	logic [APB_ADDR_BITS-1:0] paddr     = '0;
	logic [APB_DATA_BITS-1:0] pwdata    = '0;
	logic [APB_DATA_BITS-1:0] prdata;
	logic                     pready;
	logic                     s_tvalid  = 1'b0;
	logic                     s_tready;
	// start_x, start_y, end_x, end_y
	logic [S_DATA_BITS-1:0]   s_tdata   = '0;
	// command
	logic                     s_tuser   = CMD_START;
	logic                     m_tvalid;
	logic                     m_tready  = 1'b0;
	// pixel_x, pixel_y, pixel_color
	logic [M_DATA_BITS-1:0]   m_tdata;
	logic                     m_tlast;

	// expected pixels, oldest first
	pixel_t pending_pixels[$];
	int     mismatches = 0;
	int     items_sent = 0;
	int     sender_idle_pct = 0;
	int     receiver_stall_pct = 0;
	int     hold_left = 0;
	int     quiet_cycles = 0;

	// predicted line state and colour register
	colour_t draw_colour = COLOR_RESET;
	logic    drawing     = 1'b0;
	coord_t  cur_x       = '0;
	coord_t  cur_y       = '0;
	coord_t  major_end   = '0;
	int      span        = 0;
	int      minor_step2 = 0;
	int      major_step2 = 0;
	int      err_acc     = 0;
	logic    x_back      = 1'b0;
	logic    y_back      = 1'b0;
	logic    x_major     = 1'b0;

	line_rasterizer #(.COORD_BITS(COORD_BITS)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// bresenham step for one accepted command, queues the pixel it draws
	task automatic predict_pixel(input cmd_t cmd, input coord_t sx, input coord_t sy,
			input coord_t ex, input coord_t ey);
		int     dx_abs;
		int     dy_abs;
		coord_t major_now;
		logic   at_end;
		if (cmd == CMD_START) begin
			x_back = ex < sx;
			y_back = ey < sy;
			dx_abs = x_back ? sx - ex : ex - sx;
			dy_abs = y_back ? sy - ey : ey - sy;
			x_major = dy_abs <= dx_abs;
			if (x_major) begin
				span = dx_abs;
				minor_step2 = 2 * dy_abs;
				major_end = ex;
			end else begin
				span = dy_abs;
				minor_step2 = 2 * dx_abs;
				major_end = ey;
			end
			major_step2 = 2 * span;
			err_acc = 0;
			cur_x = sx;
			cur_y = sy;
			drawing = (dx_abs != 0) || (dy_abs != 0);
			pending_pixels.push_back('{cur_x, cur_y, draw_colour, !drawing});
		end else if (drawing) begin
			if (x_major)
				cur_x = x_back ? cur_x - 1'b1 : cur_x + 1'b1;
			else
				cur_y = y_back ? cur_y - 1'b1 : cur_y + 1'b1;
			err_acc += minor_step2;
			if (err_acc > span) begin
				if (x_major)
					cur_y = y_back ? cur_y - 1'b1 : cur_y + 1'b1;
				else
					cur_x = x_back ? cur_x - 1'b1 : cur_x + 1'b1;
				err_acc -= major_step2;
			end
			major_now = x_major ? cur_x : cur_y;
			at_end = major_now == major_end;
			if (at_end)
				drawing = 1'b0;
			pending_pixels.push_back('{cur_x, cur_y, draw_colour, at_end});
		end
	endtask

	// offers one command, entered and left just after a falling edge
	task automatic send_item(input cmd_t cmd, input coord_t sx, input coord_t sy,
			input coord_t ex, input coord_t ey);
		int gap;
		gap = 0;
		while (gap < GAP_CAP && $urandom_range(99) < sender_idle_pct)
			gap++;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= S_DATA_BITS'({ey, ex, sy, sx});
		do @(posedge clk); while (!s_tready);
		predict_pixel(cmd, sx, sy, ex, ey);
		items_sent++;
		@(negedge clk);
	endtask

	// advance command with random don't-care fields
	task automatic send_advance();
		send_item(CMD_ADVANCE, coord_t'($urandom), coord_t'($urandom),
			coord_t'($urandom), coord_t'($urandom));
	endtask

	// drops tvalid and waits until every pixel is back and the pipe is empty
	task automatic settle();
		s_tvalid <= 1'b0;
		while (pending_pixels.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// writes the colour register, then reads it back
	task automatic apply_colour(input colour_t value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {REG_DRAW_COLOR, 2'b00};
		pwdata  <= APB_DATA_BITS'(value);
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		draw_colour = value;
		@(negedge clk);
		pwrite  <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata[COLOR_BITS-1:0] !== value) begin
			$error("draw_color readback: expected %h, actual %h", value,
				prdata[COLOR_BITS-1:0]);
			mismatches++;
		end
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// directed lines, mostly at the coordinate extremes, with the reset colour
	task automatic test_lines_directed();
		sender_idle_pct = 0;
		receiver_stall_pct = 0;
		// advance with no line running
		send_advance();
		// single-point line, then an advance that must stay silent
		send_item(CMD_START, 10'd5, 10'd5, 10'd5, 10'd5);
		send_advance();
		// full-width diagonal, abandoned after three steps
		send_item(CMD_START, 10'd1023, 10'd0, 10'd0, 10'd1023);
		repeat (3) send_advance();
		// horizontal run to its end and one advance past it
		send_item(CMD_START, 10'd0, 10'd1023, 10'd3, 10'd1023);
		repeat (4) send_advance();
		// vertical run stepping down
		send_item(CMD_START, 10'd1023, 10'd1023, 10'd1023, 10'd1020);
		repeat (3) send_advance();
		// steep line, y major with x stepping back
		send_item(CMD_START, 10'd10, 10'd0, 10'd8, 10'd5);
		repeat (5) send_advance();
	endtask

	// random lines, mostly drawn to the end, some cut short, some noise
	task automatic test_random_lines(input int idle_pct, input int stall_pct,
			input colour_t colour, input int count);
		int     target;
		int     sx, sy, ex, ey, d;
		int     steps;
		settle();
		apply_colour(colour);
		sender_idle_pct = idle_pct;
		receiver_stall_pct = stall_pct;
		target = items_sent + count;
		while (items_sent < target) begin
			if ($urandom_range(4) == 0) begin
				// noise transaction with any content
				send_item(cmd_t'($urandom_range(1)), coord_t'($urandom), coord_t'($urandom),
					coord_t'($urandom), coord_t'($urandom));
			end else begin
				sx = $urandom_range(COORD_MAX);
				sy = $urandom_range(COORD_MAX);
				d = ($urandom_range(9) == 0) ? $urandom_range(60) : $urandom_range(12);
				ex = $urandom_range(1) ? ((sx + d > COORD_MAX) ? COORD_MAX : sx + d)
					: ((sx < d) ? 0 : sx - d);
				d = ($urandom_range(9) == 0) ? $urandom_range(60) : $urandom_range(12);
				ey = $urandom_range(1) ? ((sy + d > COORD_MAX) ? COORD_MAX : sy + d)
					: ((sy < d) ? 0 : sy - d);
				steps = (ex > sx) ? ex - sx : sx - ex;
				d = (ey > sy) ? ey - sy : sy - ey;
				if (d > steps)
					steps = d;
				// cut the line short now and then
				if ($urandom_range(6) == 0)
					steps = $urandom_range(steps);
				// advances past the end now and then
				else if ($urandom_range(7) == 0)
					steps += $urandom_range(1, 2);
				send_item(CMD_START, coord_t'(sx), coord_t'(sy), coord_t'(ex), coord_t'(ey));
				repeat (steps) send_advance();
			end
		end
	endtask

	// receiver holds off long enough for the block to fill and stall its input
	task automatic test_backpressure();
		settle();
		apply_colour(16'h07E0);
		sender_idle_pct = 0;
		receiver_stall_pct = 0;
		hold_left = HOLD_CYCLES;
		send_item(CMD_START, 10'd100, 10'd200, 10'd130, 10'd215);
		repeat (30) send_advance();
	endtask

	// receiver side: random stalls, or a long hold when asked
	always @(negedge clk) begin
		if (hold_left > 0) begin
			m_tready <= 1'b0;
			hold_left--;
		end else begin
			m_tready <= $urandom_range(99) >= receiver_stall_pct;
		end
	end

	// compares each pixel transaction with the oldest expectation
	always @(posedge clk) begin : pixel_check
		pixel_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_pixels.size() == 0) begin
				$error("unexpected pixel: x %0d y %0d colour %h last %b",
					m_tdata[9:0], m_tdata[19:10], m_tdata[35:20], m_tlast);
				mismatches++;
			end else begin
				want = pending_pixels.pop_front();
				if (m_tdata[9:0] !== want.x) begin
					$error("pixel_x: expected %0d, actual %0d", want.x, m_tdata[9:0]);
					mismatches++;
				end
				if (m_tdata[19:10] !== want.y) begin
					$error("pixel_y: expected %0d, actual %0d", want.y, m_tdata[19:10]);
					mismatches++;
				end
				if (m_tdata[35:20] !== want.colour) begin
					$error("pixel_color: expected %h, actual %h", want.colour,
						m_tdata[35:20]);
					mismatches++;
				end
				if (m_tlast !== want.last) begin
					$error("last_pixel: expected %b, actual %b", want.last, m_tlast);
					mismatches++;
				end
			end
		end
	end

	// watchdog on cycles with no transaction on either stream
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("testbench: FAIL");
			$finish;
		end
	end

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		test_lines_directed();
		test_random_lines(0, 0, 16'h0000, 150);
		test_random_lines(78, 0, 16'hFFFF, 150);
		test_random_lines(0, 78, colour_t'($urandom), 150);
		test_random_lines(31, 31, 16'hA55A, 150);
		test_backpressure();

		// drain and report
		s_tvalid <= 1'b0;
		while (pending_pixels.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_pixels.size() == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

endmodule

@@ files.f @@
design/lr_pkg.sv
design/lr_apb.sv
design/lr_core.sv
design/line_rasterizer.sv
test/testbench.sv
